>>> sv/wsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg: shared types and constants for the window deviation detector
// Widths of the sample path, the running sums and the serial units, plus the
// control bundle that drives the bit-serial squaring units.
// ----------------------------------------------------------------------------
package wsd_pkg;

   // window geometry
   localparam int WIN_LEN  = 32;
   localparam int WPOS_W   = 5;                 // index into the window

   // field widths
   localparam int SAMPLE_W = 15;
   localparam int DEV_W    = 14;

   // running sums: |sum x| <= 32 * 2^14, sum x^2 <= 32 * 2^28
   localparam int SUM_W    = 20;
   localparam int S2_W     = 34;

   // bit-serial squarer: operand and product widths
   localparam int SQ_OP_W  = 20;
   localparam int SQ_W     = 2 * SQ_OP_W;
   localparam int XSQ_W    = 29;                // square of one sample

   // N*(N-1) = 32 * 31: divide by 32 with a shift, by 31 serially
   localparam int NUM_W    = S2_W + 5;
   localparam int DIVR     = 31;
   localparam int REM_W    = 5;

   // square root: two radicand bits per step
   localparam int ROOT_W   = S2_W / 2;
   localparam int SREM_W   = ROOT_W + 2;

   // step counts of the serial phases
   localparam int MUL_STEPS  = SQ_OP_W;
   localparam int DIV_STEPS  = S2_W / 2;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int CNT_W      = 5;

   localparam logic [DEV_W-1:0] DEV_SENTINEL  = 14'd9900;
   localparam logic [DEV_W-1:0] THRESH_RESET  = 14'd10;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // control bundle for one squaring unit
   typedef struct packed {
      logic start;   // load operand, clear accumulator
      logic step;    // one shift-add step
   } sqr_ctl_type;

endpackage

>>> sv/wsd_sqr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_sqr: bit-serial squaring unit
// Squares an unsigned operand by shift-and-add, one multiplier bit per step.
// The product is valid after SQ_OP_W steps following a start.
// ----------------------------------------------------------------------------
module wsd_sqr (
   input  logic                           clock,
   input  wsd_pkg::sqr_ctl_type           ctl,
   input  logic [wsd_pkg::SQ_OP_W-1:0]    operand,
   output logic [wsd_pkg::SQ_W-1:0]       product
);

   logic [wsd_pkg::SQ_W-1:0]    mcand_ff, mcand_in;
   logic [wsd_pkg::SQ_OP_W-1:0] mplier_ff, mplier_in;
   logic [wsd_pkg::SQ_W-1:0]    acc_ff, acc_in;

   // shift-add step
   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      if (ctl.start) begin
         mcand_in  = {{(wsd_pkg::SQ_W - wsd_pkg::SQ_OP_W){1'b0}}, operand};
         mplier_in = operand;
         acc_in    = '0;
      end else if (ctl.step) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[wsd_pkg::SQ_W-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[wsd_pkg::SQ_OP_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
   end

   assign product = acc_ff;

endmodule

>>> sv/window_stddev_stability_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_stddev_stability_detector: sliding window deviation of temperature
// One sample in, one result out. Keeps a 32-entry circular window with running
// sums and reports the sample standard deviation and a stability flag.
// ----------------------------------------------------------------------------
// Each sample beat yields exactly one result beat. An item is processed from
// the cycle it is accepted in through the cycle that registers its result:
// accept, load, 20 squaring steps (bit-serial, sized by the 20-bit window sum),
// sum update, divide setup, 17 steps of the divide by 31 (two quotient bits a
// step) and 17 square root steps (two radicand bits a step), then the result is
// registered once the previous result has been taken; the next sample is taken
// once the result has been registered, while that result may still wait for
// rsp_tready. Until 32 samples have been seen the result carries deviation
// 9900, stable = 0 and window_full = 0. Deviation saturates at 9900. stable is
// set when the deviation is below the threshold written on csr_wr_data (reset
// value 10). Write the threshold only while no sample is in flight.
// ----------------------------------------------------------------------------
module window_stddev_stability_detector (
   input  logic        clock,
   input  logic        reset,
   // sample channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // [14:0] temperature_sample, [15] zero
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [13:0] std_deviation, [14] stable,
                                     // [15] window_full
   // threshold register
   input  logic        csr_wr_en,
   input  logic [13:0] csr_wr_data
);

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOAD = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_UPD  = 3'd3;
   localparam logic [2:0] ST_PREP = 3'd4;
   localparam logic [2:0] ST_DIV  = 3'd5;
   localparam logic [2:0] ST_SQRT = 3'd6;
   localparam logic [2:0] ST_FIN  = 3'd7;

   localparam int SW = wsd_pkg::SAMPLE_W;
   localparam int UW = wsd_pkg::SUM_W;

   // control state
   logic [2:0]                     state_ff, state_in;
   logic [wsd_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic [wsd_pkg::WPOS_W-1:0]     wpos_ff, wpos_in;
   logic                           filled_ff, filled_in;
   logic [wsd_pkg::DEV_W-1:0]      thr_ff, thr_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // datapath state
   logic                           old_valid_ff;
   wsd_pkg::sample_type            sample_ff;
   wsd_pkg::sample_type            rd_ff;
   logic signed [UW-1:0]           s1_ff, s1_in;
   logic [wsd_pkg::S2_W-1:0]       s2_ff, s2_in;
   logic [wsd_pkg::S2_W-1:0]       dq_ff, dq_in;
   logic [wsd_pkg::REM_W-1:0]      rem_ff, rem_in;
   logic [wsd_pkg::SREM_W-1:0]     srem_ff, srem_in;
   logic [wsd_pkg::ROOT_W-1:0]     root_ff, root_in;
   logic [15:0]                    rsp_data_ff;

   wsd_pkg::sample_type            window_mem [wsd_pkg::WIN_LEN];

   logic                           accept;
   logic                           rsp_free;
   wsd_pkg::sample_type            old_sample;
   logic signed [UW-1:0]           new_ext, old_ext, s1_sum;
   logic [UW-1:0]                  mag_new, mag_old, mag_s1;
   wsd_pkg::sqr_ctl_type           sqr_ctl;
   logic [wsd_pkg::SQ_W-1:0]       sq_new, sq_old, sq_s1;
   logic [wsd_pkg::NUM_W-1:0]      num;
   logic [wsd_pkg::REM_W:0]        dv_t1, dv_t2;
   logic                           dv_ge1, dv_ge2;
   logic [wsd_pkg::REM_W-1:0]      dv_r1;
   logic [wsd_pkg::SREM_W+1:0]     sq_t, sq_trial;
   logic [wsd_pkg::DEV_W-1:0]      dev_sat, dev_out;
   logic                           stable_out;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // window memory: read-before-write at the write position
   always_ff @(posedge clock) begin
      if (accept) begin
         window_mem[wpos_ff] <= req_tdata[SW-1:0];
         rd_ff               <= window_mem[wpos_ff];
         sample_ff           <= req_tdata[SW-1:0];
         old_valid_ff        <= filled_ff;
      end
   end

   // entry being replaced is zero until the window has filled once
   assign old_sample = old_valid_ff ? rd_ff : '0;
   assign new_ext    = UW'(sample_ff);
   assign old_ext    = UW'(old_sample);
   assign s1_sum     = s1_ff + new_ext - old_ext;
   assign mag_new    = new_ext[UW-1] ? UW'(-new_ext) : UW'(new_ext);
   assign mag_old    = old_ext[UW-1] ? UW'(-old_ext) : UW'(old_ext);
   assign mag_s1     = s1_sum[UW-1]  ? UW'(-s1_sum)  : UW'(s1_sum);

   assign sqr_ctl.start = (state_ff == ST_LOAD);
   assign sqr_ctl.step  = (state_ff == ST_MUL);

   wsd_sqr u_sqr_new (.clock(clock), .ctl(sqr_ctl), .operand(mag_new), .product(sq_new));
   wsd_sqr u_sqr_old (.clock(clock), .ctl(sqr_ctl), .operand(mag_old), .product(sq_old));
   wsd_sqr u_sqr_s1  (.clock(clock), .ctl(sqr_ctl), .operand(mag_s1),  .product(sq_s1));

   // N * sum(x^2) - (sum x)^2
   assign num = {s2_ff, 5'b0} - sq_s1[wsd_pkg::NUM_W-1:0];

   // divide by 31: two restoring steps per cycle
   assign dv_t1  = {rem_ff, dq_ff[wsd_pkg::S2_W-1]};
   assign dv_ge1 = (dv_t1 >= (wsd_pkg::REM_W+1)'(wsd_pkg::DIVR));
   assign dv_r1  = dv_ge1 ? wsd_pkg::REM_W'(dv_t1 - (wsd_pkg::REM_W+1)'(wsd_pkg::DIVR))
                          : dv_t1[wsd_pkg::REM_W-1:0];
   assign dv_t2  = {dv_r1, dq_ff[wsd_pkg::S2_W-2]};
   assign dv_ge2 = (dv_t2 >= (wsd_pkg::REM_W+1)'(wsd_pkg::DIVR));

   // square root: bring down two bits, trial subtract 4*root+1
   assign sq_t     = {srem_ff, dq_ff[wsd_pkg::S2_W-1 -: 2]};
   assign sq_trial = {2'b00, root_ff, 2'b01};

   // saturation and threshold compare
   assign dev_sat    = (root_ff > wsd_pkg::ROOT_W'(wsd_pkg::DEV_SENTINEL))
                       ? wsd_pkg::DEV_SENTINEL : root_ff[wsd_pkg::DEV_W-1:0];
   assign dev_out    = filled_ff ? dev_sat : wsd_pkg::DEV_SENTINEL;
   assign stable_out = filled_ff && (dev_sat < thr_ff);

   // sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      wpos_in      = wpos_ff;
      filled_in    = filled_ff;
      thr_in       = csr_wr_en ? csr_wr_data : thr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      dq_in        = dq_ff;
      rem_in       = rem_ff;
      srem_in      = srem_ff;
      root_in      = root_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               wpos_in  = wpos_ff + 1'b1;
               if (wpos_ff == wsd_pkg::WPOS_W'(wsd_pkg::WIN_LEN - 1)) begin
                  filled_in = 1'b1;
               end
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            s1_in    = s1_sum;
            cnt_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == wsd_pkg::CNT_W'(wsd_pkg::MUL_STEPS - 1)) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            s2_in    = s2_ff + wsd_pkg::S2_W'(sq_new[wsd_pkg::XSQ_W-1:0])
                             - wsd_pkg::S2_W'(sq_old[wsd_pkg::XSQ_W-1:0]);
            state_in = ST_PREP;
         end
         ST_PREP: begin
            dq_in    = num[wsd_pkg::NUM_W-1:5];
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            dq_in  = {dq_ff[wsd_pkg::S2_W-3:0], dv_ge1, dv_ge2};
            rem_in = dv_ge2 ? wsd_pkg::REM_W'(dv_t2 - (wsd_pkg::REM_W+1)'(wsd_pkg::DIVR))
                            : dv_t2[wsd_pkg::REM_W-1:0];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == wsd_pkg::CNT_W'(wsd_pkg::DIV_STEPS - 1)) begin
               srem_in  = '0;
               root_in  = '0;
               cnt_in   = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            dq_in = {dq_ff[wsd_pkg::S2_W-3:0], 2'b00};
            if (sq_t >= sq_trial) begin
               srem_in = wsd_pkg::SREM_W'(sq_t - sq_trial);
               root_in = {root_ff[wsd_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               srem_in = sq_t[wsd_pkg::SREM_W-1:0];
               root_in = {root_ff[wsd_pkg::ROOT_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == wsd_pkg::CNT_W'(wsd_pkg::SQRT_STEPS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         wpos_ff      <= '0;
         filled_ff    <= 1'b0;
         thr_ff       <= wsd_pkg::THRESH_RESET;
         rsp_valid_ff <= 1'b0;
         s1_ff        <= '0;
         s2_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         wpos_ff      <= wpos_in;
         filled_ff    <= filled_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
      end
   end

   // serial unit registers and result beat
   always_ff @(posedge clock) begin
      dq_ff   <= dq_in;
      rem_ff  <= rem_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      if (state_ff == ST_FIN && rsp_free) begin
         rsp_data_ff <= {filled_ff, stable_out, dev_out};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // an accepted beat starts the sequencer
   a_accept_load: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_LOAD))
      else $error("accepted beat did not start processing");

   // deviation never exceeds the sentinel
   a_dev_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[13:0] <= wsd_pkg::DEV_SENTINEL))
      else $error("deviation above saturation value");

   // stable only with a full window; sentinel while not full
   a_stable_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff[15]) |->
         (!rsp_data_ff[14] && rsp_data_ff[13:0] == wsd_pkg::DEV_SENTINEL))
      else $error("result before full window is not the sentinel");

   // divider remainder stays reduced
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < wsd_pkg::REM_W'(wsd_pkg::DIVR)))
      else $error("divider remainder out of range");

   // no new beat while the sequencer is busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("ready raised while busy");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the window deviation stability detector
// Streams temperature samples through the block, predicts each result from a
// private copy of the 32-entry window and the threshold, and compares every
// result beat field by field. Both stream sides idle at random outside the steady
// phase; the threshold is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 157;
   localparam int QUIET_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 70;

   typedef struct packed {
      logic                      full;
      logic                      stable;
      logic [wsd_pkg::DEV_W-1:0] dev;
   } stability_result_type;

   typedef enum int {MODE_RANGE, MODE_FULL, MODE_STEADY, MODE_SWING, MODE_DRIFT}
      stim_mode_type;

   // predicts each result beat and holds the ones still outstanding
   class window_deviation_book;
      wsd_pkg::sample_type       window [wsd_pkg::WIN_LEN];
      int unsigned               wpos;
      bit                        filled;
      logic [wsd_pkg::DEV_W-1:0] thresh;
      stability_result_type      pending_q [$];
      int                        errors;

      function new();
         foreach (window[i]) window[i] = '0;
         wpos   = 0;
         filled = 1'b0;
         thresh = wsd_pkg::THRESH_RESET;
         errors = 0;
      endfunction

      function void set_threshold(logic [wsd_pkg::DEV_W-1:0] t);
         thresh = t;
      endfunction

      function int pending();
         return pending_q.size();
      endfunction

      // bitwise integer root, largest r with r*r <= v
      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned r;
         longint unsigned c;
         r = 0;
         for (int b = 20; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (c * c <= v) r = c;
         end
         return r;
      endfunction

      // beat accepted on the sample channel: update window, queue its result
      function void note_sample(wsd_pkg::sample_type s);
         longint               sum1;
         longint               sum2;
         longint               x;
         longint unsigned      spread;
         longint unsigned      root;
         stability_result_type r;
         window[wpos] = s;
         wpos = (wpos + 1) % wsd_pkg::WIN_LEN;
         if (wpos == 0) filled = 1'b1;
         r.dev    = wsd_pkg::DEV_SENTINEL;
         r.stable = 1'b0;
         r.full   = filled;
         if (filled) begin
            sum1 = 0;
            sum2 = 0;
            foreach (window[i]) begin
               x = window[i];
               sum1 += x;
               sum2 += x * x;
            end
            spread = (wsd_pkg::WIN_LEN * sum2 - sum1 * sum1)
                     / (wsd_pkg::WIN_LEN * (wsd_pkg::WIN_LEN - 1));
            root = int_sqrt(spread);
            if (root > wsd_pkg::DEV_SENTINEL) root = wsd_pkg::DEV_SENTINEL;
            r.dev    = root[wsd_pkg::DEV_W-1:0];
            r.stable = (r.dev < thresh);
         end
         pending_q.push_back(r);
      endfunction

      // beat accepted on the result channel
      function void check_result(logic [15:0] beat);
         stability_result_type got;
         stability_result_type want;
         got = beat;
         if (pending_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat, expected none, actual %h", $time, beat);
            return;
         end
         want = pending_q.pop_front();
         if (got.dev !== want.dev) begin
            errors++;
            $display("%0t: std_deviation expected %0d actual %0d", $time, want.dev, got.dev);
         end
         if (got.stable !== want.stable) begin
            errors++;
            $display("%0t: stable expected %b actual %b", $time, want.stable, got.stable);
         end
         if (got.full !== want.full) begin
            errors++;
            $display("%0t: window_full expected %b actual %b", $time, want.full, got.full);
         end
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata   = '0;    // [14:0] temperature_sample, [15] zero
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;           // [13:0] std_deviation, [14] stable,
                                     // [15] window_full
   logic        csr_wr_en   = 1'b0;
   logic [13:0] csr_wr_data = '0;

   window_deviation_book book = new();

   bit          steady      = 1'b0;  // no idling on either side
   int          hold_left   = 0;
   int          quiet_cycles = 0;
   int          phase_base;
   int          phase_spread;
   int          ramp_value;

   wsd_pkg::sample_type edge_samples [13] = '{-16384, 16383, 0, -1, 1, -4500, 13000,
                                              -4501, 13001, 15'sh2AAA, 15'sh5555,
                                              -16383, 16382};

   window_stddev_stability_detector uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // result side backpressure: short random stalls plus rare long ones
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (steady) begin
         rsp_tready <= 1'b1;
      end else if ($urandom_range(199) == 0) begin
         hold_left  <= $urandom_range(20, 90);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= 26);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) book.check_result(rsp_tdata);
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL window_stddev_stability_detector");
         $finish;
      end
   end

   // one sample beat, with an optional gap ahead of it
   task automatic send_sample(input wsd_pkg::sample_type s);
      if (!steady && $urandom_range(99) < 26) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 70)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, s};
      do @(posedge clock); while (!req_tready);
      book.note_sample(s);
   endtask

   // stop sending and let every outstanding result drain
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [13:0] t);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= t;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      book.set_threshold(t);
   endtask

   function automatic logic [13:0] pick_threshold(int phase, stim_mode_type mode);
      if (mode == MODE_STEADY) return 14'($urandom_range(0, 60));
      case (phase)
         1:       return 14'd0;
         3:       return 14'h3FFF;        // saturation still reads as stable
         4:       return wsd_pkg::DEV_SENTINEL;
         5:       return 14'd9899;
         6:       return 14'h3FFF;
         8:       return wsd_pkg::DEV_SENTINEL;
         10:      return wsd_pkg::THRESH_RESET;
         11:      return 14'($urandom_range(9000, 10500));
         default: return 14'($urandom_range(0, 16383));
      endcase
   endfunction

   function automatic wsd_pkg::sample_type next_sample(stim_mode_type mode, int idx);
      int v;
      case (mode)
         MODE_RANGE:  v = int'($urandom_range(0, 17500)) - 4500;
         MODE_FULL:   v = int'($urandom_range(0, 32767));
         MODE_STEADY: v = phase_base + int'($urandom_range(0, phase_spread));
         // alternating near-extremes drive the deviation past saturation
         MODE_SWING:  v = (idx % 2) ? 16383 - int'($urandom_range(0, 200))
                                    : -16384 + int'($urandom_range(0, 200));
         default: begin
            ramp_value += int'($urandom_range(0, 40)) - 20;
            v = ramp_value;
         end
      endcase
      return wsd_pkg::sample_type'(v);
   endfunction

   initial begin
      stim_mode_type mode;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // field extremes while the window is still filling
      foreach (edge_samples[i]) send_sample(edge_samples[i]);

      for (int phase = 1; phase <= PHASES; phase++) begin
         mode = stim_mode_type'(phase % 5);
         drain_results();
         write_threshold(pick_threshold(phase, mode));
         steady       <= (phase == 5);
         phase_base   = int'($urandom_range(0, 17500)) - 4500;
         phase_spread = $urandom_range(0, 60);
         ramp_value   = phase_base;
         for (int i = 0; i < PHASE_ITEMS; i++) send_sample(next_sample(mode, i));
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (book.pending() != 0)
         $display("%0t: %0d expected results never arrived", $time, book.pending());
      if (book.errors == 0 && book.pending() == 0)
         $display("PASS window_stddev_stability_detector");
      else
         $display("FAIL window_stddev_stability_detector");
      $finish;
   end

endmodule

>>> sim.f
sv/wsd_pkg.sv
sv/wsd_sqr.sv
sv/window_stddev_stability_detector.sv
tb/tb_top.sv
